[sv/agc_pkg.sv]
// Shared types and constants for the Accept-Encoding gzip check.
package agc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF   = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_Z     = 8'h7a;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_P     = 8'h70;

    // Classified header byte handed from the front end to the parser.
    typedef struct packed {
        logic       has;
        logic       last;
        logic       is_nul;
        logic       is_comma;
        logic       is_sp;
        logic       is_semi;
        logic       is_q;
        logic       is_eq;
        logic       is_zero;
        logic       is_dot;
        logic [3:0] letter_hit;   // bit k: lowercase byte equals letter k of "gzip"
    } class_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c | 8'h20;
        end
        return r;
    endfunction

endpackage

[sv/agc_fifo.sv]
// Small register queue with a count, used between stages and for results.
module agc_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[sv/agc_front.sv]
// Front end: accepts header bytes and classifies them for the parser.
module agc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      char_code,
    input  logic            has_char,
    input  logic            last,
    output logic            q_push,
    output agc_pkg::class_t q_item,
    input  logic            q_full
);
    logic            valid_reg, valid_next;
    agc_pkg::class_t item_reg;
    agc_pkg::class_t item_new;
    logic [7:0]      lc;
    logic            accept;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_item = item_reg;

    always_comb
    begin
        lc = agc_pkg::to_lower(char_code);
        item_new.has           = has_char;
        item_new.last          = last;
        item_new.is_nul        = (char_code == agc_pkg::CH_NUL);
        item_new.is_comma      = (char_code == agc_pkg::CH_COMMA);
        item_new.is_sp         = (char_code == agc_pkg::CH_SPACE) ||
                                 (char_code == agc_pkg::CH_TAB);
        item_new.is_semi       = (char_code == agc_pkg::CH_SEMI);
        item_new.is_q          = (lc == agc_pkg::CH_Q);
        item_new.is_eq         = (char_code == agc_pkg::CH_EQ);
        item_new.is_zero       = (char_code == agc_pkg::CH_ZERO);
        item_new.is_dot        = (char_code == agc_pkg::CH_DOT);
        item_new.letter_hit[0] = (lc == agc_pkg::CH_G);
        item_new.letter_hit[1] = (lc == agc_pkg::CH_Z);
        item_new.letter_hit[2] = (lc == agc_pkg::CH_I);
        item_new.letter_hit[3] = (lc == agc_pkg::CH_P);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until the queue takes it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_new;
        end
    end

endmodule

[sv/agc_back.sv]
// Back end: header parser state machine that produces the gzip verdict.
module agc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_empty,
    input  agc_pkg::class_t in_item,
    output logic            in_pop,
    input  logic            res_full,
    output logic            res_push,
    output logic            res_data
);
    typedef enum logic [3:0] {
        PH_SKIP_LEAD  = 4'd0,
        PH_TOKEN      = 4'd1,
        PH_SKIP_ELEM  = 4'd2,
        PH_PARAM_GAP  = 4'd3,
        PH_PARAM_Q    = 4'd4,
        PH_PARAM_REST = 4'd5,
        PH_Q_SPACE    = 4'd6,
        PH_Q_ZERO     = 4'd7,
        PH_Q_TRAIL    = 4'd8
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] match_count;
        logic       token_mismatch;
        logic       decided;
        logic       verdict;
        logic       header_ended;
    } pstate_t;

    localparam logic [2:0] GZIP_LEN = 3'd4;
    localparam pstate_t PSTATE_RESET = '{
        phase: PH_SKIP_LEAD, match_count: 3'd0, token_mismatch: 1'b0,
        decided: 1'b0, verdict: 1'b0, header_ended: 1'b0
    };

    pstate_t st_reg, st_next;

    function automatic logic is_gzip(input pstate_t s);
        return (s.match_count == GZIP_LEN) && !s.token_mismatch;
    endfunction

    // Close the current element at a comma or at the end of the header.
    function automatic pstate_t finish_element(input pstate_t s);
        pstate_t r;
        r = s;
        unique case (s.phase)
            PH_TOKEN:
            begin
                if (is_gzip(s))
                begin
                    r.decided = 1'b1;
                    r.verdict = 1'b1;
                end
                else
                begin
                    r.phase = PH_SKIP_LEAD;
                end
            end
            PH_PARAM_GAP, PH_PARAM_Q, PH_PARAM_REST, PH_Q_SPACE:
            begin
                r.decided = 1'b1;
                r.verdict = 1'b1;
            end
            PH_Q_ZERO, PH_Q_TRAIL:
            begin
                r.decided = 1'b1;
                r.verdict = 1'b0;
            end
            default:
            begin
                r.phase = PH_SKIP_LEAD;
            end
        endcase
        return r;
    endfunction

    function automatic pstate_t take_byte(input pstate_t s, input agc_pkg::class_t c);
        pstate_t r;
        logic    skip;
        r    = s;
        skip = 1'b0;
        if (c.is_nul)
        begin
            r = finish_element(s);
            if (!r.decided)
            begin
                r.decided = 1'b1;
                r.verdict = 1'b0;
            end
            r.header_ended = 1'b1;
        end
        else if (c.is_comma)
        begin
            r = finish_element(s);
        end
        else
        begin
            if (r.phase == PH_SKIP_LEAD)
            begin
                if (c.is_sp)
                begin
                    skip = 1'b1;
                end
                else
                begin
                    r.match_count    = 3'd0;
                    r.token_mismatch = 1'b0;
                    r.phase          = PH_TOKEN;
                end
            end
            if (!skip)
            begin
                unique case (r.phase)
                    PH_TOKEN:
                    begin
                        if (c.is_semi || c.is_sp)
                        begin
                            r.phase = is_gzip(r) ? PH_PARAM_GAP : PH_SKIP_ELEM;
                        end
                        else if (r.match_count < GZIP_LEN &&
                                 c.letter_hit[r.match_count[1:0]])
                        begin
                            r.match_count = r.match_count + 3'd1;
                        end
                        else
                        begin
                            r.token_mismatch = 1'b1;
                        end
                    end
                    PH_PARAM_GAP:
                    begin
                        if (!(c.is_sp || c.is_semi))
                        begin
                            r.phase = c.is_q ? PH_PARAM_Q : PH_PARAM_REST;
                        end
                    end
                    PH_PARAM_Q:
                    begin
                        priority if (c.is_eq)
                        begin
                            r.phase = PH_Q_SPACE;
                        end
                        else if (c.is_semi)
                        begin
                            r.phase = PH_PARAM_GAP;
                        end
                        else
                        begin
                            r.phase = PH_PARAM_REST;
                        end
                    end
                    PH_PARAM_REST:
                    begin
                        if (c.is_semi)
                        begin
                            r.phase = PH_PARAM_GAP;
                        end
                    end
                    PH_Q_SPACE:
                    begin
                        if (c.is_zero)
                        begin
                            r.phase = PH_Q_ZERO;
                        end
                        else if (!c.is_sp)
                        begin
                            r.decided = 1'b1;
                            r.verdict = 1'b1;
                        end
                    end
                    PH_Q_ZERO:
                    begin
                        if (c.is_sp)
                        begin
                            r.phase = PH_Q_TRAIL;
                        end
                        else if (c.is_semi)
                        begin
                            r.decided = 1'b1;
                            r.verdict = 1'b0;
                        end
                        else if (!c.is_zero && !c.is_dot)
                        begin
                            r.decided = 1'b1;
                            r.verdict = 1'b1;
                        end
                    end
                    PH_Q_TRAIL:
                    begin
                        if (c.is_semi)
                        begin
                            r.decided = 1'b1;
                            r.verdict = 1'b0;
                        end
                        else if (!c.is_sp)
                        begin
                            r.decided = 1'b1;
                            r.verdict = 1'b1;
                        end
                    end
                    default:
                    begin
                        r = r;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Advance only when a result slot is free, so a last item never stalls mid-way.
    assign in_pop = !in_empty && !res_full;

    always_comb
    begin
        pstate_t s;
        s        = st_reg;
        st_next  = st_reg;
        res_push = 1'b0;
        res_data = 1'b0;
        if (in_pop)
        begin
            if (in_item.has && !s.header_ended && !s.decided)
            begin
                s = take_byte(s, in_item);
            end
            if (in_item.last)
            begin
                if (!s.decided)
                begin
                    s = finish_element(s);
                    if (!s.decided)
                    begin
                        s.decided = 1'b1;
                        s.verdict = 1'b0;
                    end
                end
                res_push = 1'b1;
                res_data = s.verdict;
                st_next  = PSTATE_RESET;
            end
            else
            begin
                st_next = s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= PSTATE_RESET;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

[sv/accept_encoding_gzip_check.sv]
// Accept-Encoding gzip check: one header byte per transaction, one verdict per header.
// A verdict passes through the front register, the byte queue and the result queue before it can be popped.
// Throughput: one byte per cycle while no queue is full; the back end parser takes one byte per pop.
// Front register, byte queue and result queue decouple both sides from stalls.
// Reset (rst_n low, asynchronous): queues empty, parser at skip-leading-separators.
// Parser state returns to its reset value after every header's last byte.
module accept_encoding_gzip_check #(
    parameter int QUEUE_DEPTH = agc_pkg::QUEUE_DEPTH_DEF,
    parameter int OUT_DEPTH   = agc_pkg::OUT_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_code,
    input  logic       has_char,
    input  logic       last,
    output logic       empty,
    input  logic       pop,
    output logic       gzip_accepted
);
    localparam int CW = $bits(agc_pkg::class_t);

    logic            q_push, q_full, q_empty, q_pop;
    agc_pkg::class_t q_wr_item, q_rd_item;
    logic [CW-1:0]   q_wdata, q_rdata;
    logic            res_push, res_full, res_data;

    agc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .has_char  (has_char),
        .last      (last),
        .q_push    (q_push),
        .q_item    (q_wr_item),
        .q_full    (q_full)
    );

    assign q_wdata   = q_wr_item;
    assign q_rd_item = agc_pkg::class_t'(q_rdata);

    agc_fifo #(
        .WIDTH (CW),
        .DEPTH (QUEUE_DEPTH)
    ) u_byte_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    agc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (q_empty),
        .in_item  (q_rd_item),
        .in_pop   (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_data)
    );

    agc_fifo #(
        .WIDTH (1),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (gzip_accepted),
        .empty (empty)
    );

endmodule

[verif/agc_verdict_checker.sv]
// Checker for the gzip check: predicts each header verdict and compares it with the result port.
`timescale 1ns / 100ps

module agc_verdict_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] char_code,
    input  logic       has_char,
    input  logic       last,
    input  logic       empty,
    input  logic       pop,
    input  logic       gzip_accepted,
    output int         pending,
    output int         fail_count
);

    typedef enum logic [3:0] {
        P_LEAD,
        P_TOKEN,
        P_SKIP,
        P_GAP,
        P_QNAME,
        P_REST,
        P_QSPACE,
        P_QZERO,
        P_QTRAIL
    } phase_e;

    phase_e     phase;
    logic [2:0] hits;
    logic       bad_tok;
    logic       fixed;
    logic       answer;
    logic       ended;

    bit verdict_q[$];
    bit want;
    int errors;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] gzip_char(input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = agc_pkg::CH_G;
            2'd1:    r = agc_pkg::CH_Z;
            2'd2:    r = agc_pkg::CH_I;
            default: r = agc_pkg::CH_P;
        endcase
        return r;
    endfunction

    function logic tok_is_gzip();
        return hits == 3'd4 && !bad_tok;
    endfunction

    task set_verdict(input logic v);
        fixed  = 1'b1;
        answer = v;
    endtask

    task clear_parse();
        phase   = P_LEAD;
        hits    = 3'd0;
        bad_tok = 1'b0;
        fixed   = 1'b0;
        answer  = 1'b0;
        ended   = 1'b0;
    endtask

    // Close the current element at a comma or at the end of the header.
    task close_element();
        case (phase)
            P_TOKEN:
            begin
                if (tok_is_gzip())
                begin
                    set_verdict(1'b1);
                end
                else
                begin
                    phase = P_LEAD;
                end
            end
            P_GAP, P_QNAME, P_REST, P_QSPACE:
            begin
                set_verdict(1'b1);
            end
            P_QZERO, P_QTRAIL:
            begin
                set_verdict(1'b0);
            end
            default:
            begin
                phase = P_LEAD;
            end
        endcase
    endtask

    task automatic eat_byte(input logic [7:0] c);
        logic sp;
        sp = (c == agc_pkg::CH_SPACE || c == agc_pkg::CH_TAB);
        if (c == agc_pkg::CH_NUL)
        begin
            close_element();
            if (!fixed)
            begin
                set_verdict(1'b0);
            end
            ended = 1'b1;
        end
        else if (c == agc_pkg::CH_COMMA)
        begin
            close_element();
        end
        else
        begin
            // Start a new token on the first byte that is not a blank.
            if (phase == P_LEAD && !sp)
            begin
                hits    = 3'd0;
                bad_tok = 1'b0;
                phase   = P_TOKEN;
            end
            case (phase)
                P_TOKEN:
                begin
                    if (c == agc_pkg::CH_SEMI || sp)
                    begin
                        phase = tok_is_gzip() ? P_GAP : P_SKIP;
                    end
                    else if (hits < 3'd4 && fold_case(c) == gzip_char(hits[1:0]))
                    begin
                        hits = hits + 3'd1;
                    end
                    else
                    begin
                        bad_tok = 1'b1;
                    end
                end
                P_GAP:
                begin
                    if (!(sp || c == agc_pkg::CH_SEMI))
                    begin
                        phase = (fold_case(c) == agc_pkg::CH_Q) ? P_QNAME : P_REST;
                    end
                end
                P_QNAME:
                begin
                    if (c == agc_pkg::CH_EQ)
                    begin
                        phase = P_QSPACE;
                    end
                    else if (c == agc_pkg::CH_SEMI)
                    begin
                        phase = P_GAP;
                    end
                    else
                    begin
                        phase = P_REST;
                    end
                end
                P_REST:
                begin
                    if (c == agc_pkg::CH_SEMI)
                    begin
                        phase = P_GAP;
                    end
                end
                P_QSPACE:
                begin
                    if (c == agc_pkg::CH_ZERO)
                    begin
                        phase = P_QZERO;
                    end
                    else if (!sp)
                    begin
                        set_verdict(1'b1);
                    end
                end
                P_QZERO:
                begin
                    if (sp)
                    begin
                        phase = P_QTRAIL;
                    end
                    else if (c == agc_pkg::CH_SEMI)
                    begin
                        set_verdict(1'b0);
                    end
                    else if (c != agc_pkg::CH_ZERO && c != agc_pkg::CH_DOT)
                    begin
                        set_verdict(1'b1);
                    end
                end
                P_QTRAIL:
                begin
                    if (c == agc_pkg::CH_SEMI)
                    begin
                        set_verdict(1'b0);
                    end
                    else if (!sp)
                    begin
                        set_verdict(1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            verdict_q.delete();
            errors = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                if (has_char && !ended && !fixed)
                begin
                    eat_byte(char_code);
                end
                if (last)
                begin
                    if (!fixed)
                    begin
                        close_element();
                        if (!fixed)
                        begin
                            set_verdict(1'b0);
                        end
                    end
                    verdict_q.push_back(answer);
                    clear_parse();
                end
            end
            if (pop && !empty)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: verdict %0b popped with none expected",
                                 $time, gzip_accepted);
                    end
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (gzip_accepted !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: verdict mismatch: expected %0b, got %0b",
                                     $time, want, gzip_accepted);
                        end
                    end
                end
            end
            pending    <= verdict_q.size();
            fail_count <= errors;
        end
    end

endmodule

[verif/accept_encoding_gzip_check_tb.sv]
// Testbench top for the gzip check: header stimulus, result draining and the verdict.
`timescale 1ns / 100ps

module accept_encoding_gzip_check_tb;

    localparam int RANDOM_ITEMS = 1800;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_LEN     = 400;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       push          = 1'b0;
    logic       full;
    logic [7:0] char_code     = 8'h00;
    logic       has_char      = 1'b0;
    logic       last          = 1'b0;
    logic       empty;
    logic       pop           = 1'b0;
    logic       gzip_accepted;

    int pending;
    int fail_count;
    int stall_cycles = 0;
    int sent         = 0;
    int rx_cycle     = 0;
    bit calm         = 1'b0;

    logic [7:0] hdr[$];

    string tokens[9] = '{"gzip", "deflate", "br", "gzi", "gzipp", "x-gzip", "*",
                         "identity", "g"};
    string qvals[11] = '{"0", "0.0", "0.000", "1", "0.5", "", "00.", "0 ", "0\t;",
                         "0x", "1.0"};
    string seps[4]   = '{";", " ;", "; ", ";\t"};
    string others[4] = '{"level=9", "q", "qq=0", "v=0"};

    accept_encoding_gzip_check DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_code     (char_code),
        .has_char      (has_char),
        .last          (last),
        .empty         (empty),
        .pop           (pop),
        .gzip_accepted (gzip_accepted)
    );

    agc_verdict_checker verdict_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_code     (char_code),
        .has_char      (has_char),
        .last          (last),
        .empty         (empty),
        .pop           (pop),
        .gzip_accepted (gzip_accepted),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("** accept_encoding_gzip_check: FAILED **");
        $finish;
    end

    // Drain results; hold off once for a long stretch so the block backs up.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN)
            begin
                pop <= 1'b0;
            end
            else if (rx_cycle >= 1200 && rx_cycle < 1500)
            begin
                pop <= 1'b1;
            end
            else
            begin
                pop <= ($urandom_range(99) >= 7);
            end
        end
    end

    // Offer one transaction and hold it until it is accepted.
    task automatic offer(input logic [7:0] c, input logic h, input logic l);
        while (!calm && $urandom_range(99) < 7)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        char_code <= c;
        has_char  <= h;
        last      <= l;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            hdr.push_back(s[i]);
        end
    endtask

    task automatic add_element();
        string      tok;
        logic [7:0] c;
        case ($urandom_range(3))
            0:       add_text(" ");
            1:       add_text("\t");
            2:       add_text(", ");
            default: ;
        endcase
        tok = $urandom_range(1) ? "gzip" : tokens[$urandom_range(8)];
        for (int i = 0; i < tok.len(); i++)
        begin
            c = tok[i];
            if (c >= "a" && c <= "z" && $urandom_range(1))
            begin
                c = c - 8'h20;
            end
            hdr.push_back(c);
        end
        repeat ($urandom_range(2))
        begin
            add_text(seps[$urandom_range(3)]);
            if ($urandom_range(2) != 0)
            begin
                add_text($urandom_range(1) ? "q=" : "Q=");
                add_text(qvals[$urandom_range(10)]);
            end
            else
            begin
                add_text(others[$urandom_range(3)]);
            end
        end
        if ($urandom_range(3) == 0)
        begin
            add_text(" ");
        end
    endtask

    // Send the built header; mode 0 marks the last byte, otherwise (or if empty) close with an empty item.
    task automatic play(input int mode, input bit gaps);
        for (int i = 0; i < hdr.size(); i++)
        begin
            if (gaps && $urandom_range(24) == 0)
            begin
                offer(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            offer(hdr[i], 1'b1, (mode == 0) && (i == hdr.size() - 1));
        end
        if (mode != 0 || hdr.size() == 0)
        begin
            offer(8'($urandom_range(255)), 1'b0, 1'b1);
        end
        hdr.delete();
    endtask

    initial
    begin
        int kind;
        int mode;
        int cut;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Empty header, with a byte that must be ignored.
        offer(8'hff, 1'b0, 1'b1);
        add_text("GZIP");
        play(1, 1'b0);
        // Refused gzip, a terminating zero byte and a byte after it.
        offer(8'h55, 1'b0, 1'b0);
        add_text(",gzip;q=0");
        hdr.push_back(agc_pkg::CH_NUL);
        hdr.push_back(8'hff);
        play(0, 1'b0);
        // Bytes after the verdict is fixed are ignored.
        add_text(" gzip;q=1,x");
        play(0, 1'b0);

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (sent >= 1000 && sent < 1300);
            kind = $urandom_range(99);
            if (kind < 12)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    hdr.push_back(8'($urandom_range(255)));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    add_element();
                end
                // Truncate some headers mid-element.
                if (kind < 22 && hdr.size() > 1)
                begin
                    cut = $urandom_range(hdr.size() - 1);
                    hdr = hdr[0:cut];
                end
            end
            mode = $urandom_range(9);
            if (mode >= 8)
            begin
                hdr.push_back(agc_pkg::CH_NUL);
                repeat ($urandom_range(3))
                begin
                    hdr.push_back(8'($urandom_range(255)));
                end
                mode = 0;
            end
            else if (mode < 6)
            begin
                mode = 0;
            end
            play(mode, 1'b1);
        end
        calm = 1'b0;

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("** accept_encoding_gzip_check: PASSED **");
        end
        else
        begin
            $display("** accept_encoding_gzip_check: FAILED **");
        end
        $finish;
    end

endmodule
